>>> hw/rtl/olkd_pkg.sv
// ----------------------------------------------------------------------------
// olkd_pkg
// shared widths, command and status codes, and the cell control bundle
// ----------------------------------------------------------------------------
package olkd_pkg;

   localparam int KEY_W     = 32;
   localparam int CMD_W     = 3;
   localparam int ST_W      = 2;
   localparam int DEPTH_DEF = 32;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELKEY   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELFRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELBACK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                    capture;     // latch compare against match_key
      logic signed [KEY_W-1:0] match_key;
      logic signed [KEY_W-1:0] load_key;    // key entering at the front
      logic                    shift_right; // front insert
      logic                    remove_all;  // front delete
      logic                    remove_hit;  // delete at first match
      logic                    rotate;      // dump step
   } cell_ctl_type;

endpackage

>>> hw/rtl/olkd_cell.sv
// ----------------------------------------------------------------------------
// olkd_cell
// one list slot: holds a key, compares it and moves it to a neighbor
// ----------------------------------------------------------------------------
module olkd_cell #(
   parameter int DEPTH    = olkd_pkg::DEPTH_DEF,
   parameter int CELL_IDX = 0,
   parameter int CNT_W    = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  olkd_pkg::cell_ctl_type            ctl,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [olkd_pkg::KEY_W-1:0] prev_data,
   input  logic signed [olkd_pkg::KEY_W-1:0] next_data,
   input  logic signed [olkd_pkg::KEY_W-1:0] head_data,
   input  logic                              hit_in,
   input  logic signed [olkd_pkg::KEY_W-1:0] tail_in,
   output logic signed [olkd_pkg::KEY_W-1:0] data,
   output logic                              hit_out,
   output logic signed [olkd_pkg::KEY_W-1:0] tail_out
);

   logic signed [olkd_pkg::KEY_W-1:0] data_ff, data_in;
   logic                              match_ff, match_in;
   logic                              in_range;
   logic                              is_tail;

   assign in_range = (CNT_W'(CELL_IDX) < count);
   assign is_tail  = (count == CNT_W'(CELL_IDX + 1));
   // at or after the first match
   assign hit_out  = hit_in | (match_ff & in_range);
   assign tail_out = is_tail ? data_ff : tail_in;
   assign data     = data_ff;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (ctl.capture) begin
         match_in = (data_ff == ctl.match_key);
      end
      if (ctl.shift_right) begin
         data_in = prev_data;
      end else if (ctl.remove_all || (ctl.remove_hit && hit_out)) begin
         data_in = next_data;
      end else if (ctl.rotate) begin
         data_in = is_tail ? head_data : next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule

>>> hw/rtl/olkd_ctrl.sv
// ----------------------------------------------------------------------------
// olkd_ctrl
// command sequencer, element count and result register
// ----------------------------------------------------------------------------
module olkd_ctrl #(
   parameter int DEPTH = olkd_pkg::DEPTH_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [olkd_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [olkd_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [olkd_pkg::KEY_W-1:0] rsp_value,
   output logic [olkd_pkg::ST_W-1:0]         rsp_status,
   output logic                              rsp_last,
   input  logic signed [olkd_pkg::KEY_W-1:0] head_data,
   input  logic signed [olkd_pkg::KEY_W-1:0] tail_data,
   input  logic                              found,
   output olkd_pkg::cell_ctl_type            ctl,
   output logic [CNT_W-1:0]                  count
);

   typedef enum logic [1:0] {IDLE, EXEC, DUMP} state_type;

   state_type                         state_ff, state_in;
   logic [olkd_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [olkd_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  idx_ff, idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [olkd_pkg::KEY_W-1:0] rsp_value_ff, rsp_value_in;
   logic [olkd_pkg::ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              out_free;
   logic                              accept;
   logic                              empty;
   logic                              full;

   assign req_stall  = (state_ff != IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign count      = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      ctl             = '0;
      ctl.match_key   = req_key;
      ctl.load_key    = key_ff;
      ctl.capture     = accept;

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               key_in = req_key;
               // unused codes are taken and dropped
               if (req_cmd <= olkd_pkg::CMD_DUMP) begin
                  state_in = EXEC;
               end
            end
         end
         EXEC: begin
            if (out_free) begin
               state_in      = IDLE;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = olkd_pkg::ST_EMPTY;
               unique case (cmd_ff)
                  olkd_pkg::CMD_INSERT: begin
                     rsp_value_in = key_ff;
                     if (full) begin
                        rsp_status_in = olkd_pkg::ST_FULL;
                     end else begin
                        rsp_status_in   = olkd_pkg::ST_OK;
                        ctl.shift_right = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  olkd_pkg::CMD_DELKEY: begin
                     if (!empty) begin
                        if (found) begin
                           rsp_value_in   = key_ff;
                           rsp_status_in  = olkd_pkg::ST_OK;
                           ctl.remove_hit = 1'b1;
                           count_in       = count_ff - CNT_W'(1);
                        end else begin
                           rsp_status_in = olkd_pkg::ST_MISSING;
                        end
                     end
                  end
                  olkd_pkg::CMD_DELFRONT: begin
                     if (!empty) begin
                        rsp_value_in   = head_data;
                        rsp_status_in  = olkd_pkg::ST_OK;
                        ctl.remove_all = 1'b1;
                        count_in       = count_ff - CNT_W'(1);
                     end
                  end
                  olkd_pkg::CMD_DELBACK: begin
                     if (!empty) begin
                        rsp_value_in  = tail_data;
                        rsp_status_in = olkd_pkg::ST_OK;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  olkd_pkg::CMD_DUMP: begin
                     if (!empty) begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        state_in     = DUMP;
                        idx_in       = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = head_data;
               rsp_status_in = olkd_pkg::ST_OK;
               rsp_last_in   = (idx_ff == count_ff - CNT_W'(1));
               ctl.rotate    = 1'b1;
               idx_in        = idx_ff + CNT_W'(1);
               if (rsp_last_in) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

>>> hw/rtl/ordered_list_with_key_delete.sv
// update: the request is taken into the command register, executed in the EXEC state and
//   answered from the response register, which holds while the response side stalls;
//   a new command is taken only once the sequencer is back in idle; a dump sends
//   one element per cycle as the chain rotates past the head, unless the response stalls
// reset: synchronous, clears the count, the sequencer and the response valid;
//   the cells keep whatever they held and read as empty
// ----------------------------------------------------------------------------
// ordered_list_with_key_delete
// ordered key list with front insert, delete by key, front/back delete and dump
// ----------------------------------------------------------------------------
module ordered_list_with_key_delete #(
   parameter int DEPTH = olkd_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transactions
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [olkd_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [olkd_pkg::KEY_W-1:0] req_key,
   // response transactions
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [olkd_pkg::KEY_W-1:0] rsp_value,
   output logic [olkd_pkg::ST_W-1:0]         rsp_status,
   output logic                              rsp_last
);

   // count holds 0..DEPTH
   localparam int CNT_W = $clog2(DEPTH + 1);

   olkd_pkg::cell_ctl_type            ctl;
   logic [CNT_W-1:0]                  count;
   // cell i holds list position i, the front sits in cell 0
   logic signed [olkd_pkg::KEY_W-1:0] cell_data [DEPTH];
   // first-match flag ripples from the front toward the back
   logic                              hit_chain [DEPTH+1];
   // the back element is picked up as the chain passes it
   logic signed [olkd_pkg::KEY_W-1:0] tail_chain [DEPTH+1];

   assign hit_chain[0]  = 1'b0;
   assign tail_chain[0] = '0;

   // sequencer, count and response register
   olkd_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last),
      .head_data  (cell_data[0]),
      .tail_data  (tail_chain[DEPTH]),
      .found      (hit_chain[DEPTH]),
      .ctl        (ctl),
      .count      (count)
   );

   // row of cells, each trading its key with the neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [olkd_pkg::KEY_W-1:0] prev_data;
      logic signed [olkd_pkg::KEY_W-1:0] next_data;

      // new key enters the front cell on insert
      if (i == 0) begin : g_front
         assign prev_data = ctl.load_key;
      end else begin : g_mid
         assign prev_data = cell_data[i-1];
      end

      // the back cell has nothing behind it, it keeps its own key
      if (i == DEPTH - 1) begin : g_back
         assign next_data = cell_data[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      olkd_cell #(
         .DEPTH    (DEPTH),
         .CELL_IDX (i),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count),
         .prev_data (prev_data),
         .next_data (next_data),
         .head_data (cell_data[0]),
         .hit_in    (hit_chain[i]),
         .tail_in   (tail_chain[i]),
         .data      (cell_data[i]),
         .hit_out   (hit_chain[i+1]),
         .tail_out  (tail_chain[i+1])
      );
   end

endmodule

>>> hw/rtl/olkd_chk.sv
// ----------------------------------------------------------------------------
// olkd_chk
// port-level checks for the ordered key list, bound to the top level
// ----------------------------------------------------------------------------
module olkd_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [olkd_pkg::CMD_W-1:0]        req_cmd,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [olkd_pkg::KEY_W-1:0] rsp_value,
   input logic [olkd_pkg::ST_W-1:0]         rsp_status,
   input logic                              rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // any failure ends the command
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != olkd_pkg::ST_OK) |-> rsp_last)
      else $error("failure status without last");

   // empty and missing carry no element
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == olkd_pkg::ST_EMPTY
         || rsp_status == olkd_pkg::ST_MISSING) |-> (rsp_value == '0))
      else $error("nonzero value on empty or missing");

   // a real command keeps the request side busy while it runs
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd <= olkd_pkg::CMD_DUMP) |=> req_stall)
      else $error("request taken while command in flight");

endmodule

bind ordered_list_with_key_delete olkd_chk u_olkd_chk (.*);

>>> sim/olkd_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// olkd_list_checker
// watches both channels of the ordered key list, keeps its own copy of the
// list, predicts every response and compares it field by field in order
// ----------------------------------------------------------------------------
module olkd_list_checker #(
   parameter int DEPTH = olkd_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [olkd_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [olkd_pkg::KEY_W-1:0] req_key,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [olkd_pkg::KEY_W-1:0] rsp_value,
   input  logic [olkd_pkg::ST_W-1:0]         rsp_status,
   input  logic                              rsp_last,
   output int                                fail_count,
   output int                                pending_count,
   output int                                cmd_count,
   output int                                rsp_count,
   output int                                peak_fill,
   output logic [3:0]                        status_seen
);

   typedef struct packed {
      logic signed [olkd_pkg::KEY_W-1:0] value;
      logic [olkd_pkg::ST_W-1:0]         status;
      logic                              last;
   } list_rsp_type;

   logic signed [olkd_pkg::KEY_W-1:0] list_keys [$];   // front of the list at index 0
   list_rsp_type                      awaited_rsp [$];

   function automatic void await_rsp(input logic signed [olkd_pkg::KEY_W-1:0] value,
                                     input logic [olkd_pkg::ST_W-1:0] status,
                                     input logic last);
      list_rsp_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      awaited_rsp.push_back(r);
      status_seen[status] = 1'b1;
   endfunction

   // apply one command to the shadow list and queue what it must answer
   function automatic void predict_list_update(input logic [olkd_pkg::CMD_W-1:0] cmd,
                                               input logic signed [olkd_pkg::KEY_W-1:0] key);
      int hit;
      int i;
      hit = -1;
      case (cmd) inside
         olkd_pkg::CMD_INSERT: begin
            if (list_keys.size() >= DEPTH) begin
               await_rsp(key, olkd_pkg::ST_FULL, 1'b1);
            end else begin
               list_keys.push_front(key);
               await_rsp(key, olkd_pkg::ST_OK, 1'b1);
            end
         end
         olkd_pkg::CMD_DELKEY, olkd_pkg::CMD_DELFRONT, olkd_pkg::CMD_DELBACK: begin
            if (list_keys.size() == 0) begin
               await_rsp('0, olkd_pkg::ST_EMPTY, 1'b1);
            end else begin
               if (cmd == olkd_pkg::CMD_DELFRONT) begin
                  hit = 0;
               end else if (cmd == olkd_pkg::CMD_DELBACK) begin
                  hit = list_keys.size() - 1;
               end else begin
                  for (i = 0; i < list_keys.size() && hit < 0; i++)
                     if (list_keys[i] == key) hit = i;
               end
               if (hit < 0) begin
                  await_rsp('0, olkd_pkg::ST_MISSING, 1'b1);
               end else begin
                  await_rsp(list_keys[hit], olkd_pkg::ST_OK, 1'b1);
                  list_keys.delete(hit);
               end
            end
         end
         olkd_pkg::CMD_DUMP: begin
            if (list_keys.size() == 0) begin
               await_rsp('0, olkd_pkg::ST_EMPTY, 1'b1);
            end else begin
               for (i = 0; i < list_keys.size(); i++)
                  await_rsp(list_keys[i], olkd_pkg::ST_OK, i == list_keys.size() - 1);
            end
         end
         default: ;   // unused codes give no response
      endcase
      if (list_keys.size() > peak_fill) peak_fill = list_keys.size();
   endfunction

   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         list_keys.delete();
         awaited_rsp.delete();
         fail_count  = 0;
         cmd_count   = 0;
         rsp_count   = 0;
         peak_fill   = 0;
         status_seen = '0;
      end else begin
         if (req_valid && !req_stall) begin
            cmd_count++;
            predict_list_update(req_cmd, req_key);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (awaited_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: value %0d status %0d last %0d",
                           rsp_value, rsp_status, rsp_last);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (want.value !== rsp_value || want.status !== rsp_status ||
                   want.last !== rsp_last) begin
                  if (fail_count < 10)
                     $display("response %0d mismatch: value %0d/%0d status %0d/%0d last %0d/%0d",
                              rsp_count, want.value, rsp_value, want.status, rsp_status,
                              want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

>>> sim/ordered_list_with_key_delete_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_with_key_delete_test
// drives command transactions into the ordered key list with random gaps and
// response stalls; a side checker predicts and compares every response
// ----------------------------------------------------------------------------
module ordered_list_with_key_delete_test;

   // cycles with no accepted transaction on either channel before giving up
   localparam int QUIET_LIMIT  = 2000;
   // counted commands per random phase, ignored codes excluded
   localparam int PHASE_ITEMS  = 40;
   // idle percentage on each side outside the calm stretch
   localparam int IDLE_PERCENT = 29;
   // settle time after the last response
   localparam int DRAIN_CYCLES = 20;

   typedef logic [olkd_pkg::CMD_W-1:0]        cmd_type;
   typedef logic signed [olkd_pkg::KEY_W-1:0] key_type;

   // command mix of a random phase
   typedef enum {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIXED
   } phase_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   cmd_type                   req_cmd;
   key_type                   req_key;
   logic                      rsp_valid;
   logic                      rsp_stall;
   key_type                   rsp_value;
   logic [olkd_pkg::ST_W-1:0] rsp_status;
   logic                      rsp_last;

   int         fail_count;
   int         pending_count;
   int         cmd_count;
   int         rsp_count;
   int         peak_fill;
   logic [3:0] status_seen;

   bit         calm;           // no idling on either side while set
   int         quiet_cycles;
   int         random_items;

   // small key pool so that delete by key finds its target and duplicates occur
   key_type    key_pool [8];

   ordered_list_with_key_delete uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   olkd_list_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .cmd_count     (cmd_count),
      .rsp_count     (rsp_count),
      .peak_fill     (peak_fill),
      .status_seen   (status_seen)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side backpressure, changed only at the falling edge
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   // watchdog: any accepted transaction on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, pending_count);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one command transaction and hold it until accepted
   task automatic send_request(input cmd_type cmd, input key_type key);
      @(negedge clock);
      // random sender gaps, junk command and key updated each falling edge while valid is low
      while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         req_cmd   <= cmd_type'($urandom);
         req_key   <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait until every predicted response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // key from the pool most of the time, else a fresh random one that joins the pool
   function automatic key_type pick_key();
      key_type k;
      if ($urandom_range(99) < 55) begin
         k = key_pool[$urandom_range(7)];
      end else begin
         k = $urandom;
         key_pool[$urandom_range(7)] = k;
      end
      return k;
   endfunction

   // weighted command choice; the remainder goes to the unused codes
   function automatic cmd_type pick_cmd(input phase_kind_type kind);
      int r;
      int w_ins;
      int w_key;
      int w_end;
      int w_dump;
      cmd_type unused_code;
      r = $urandom_range(99);
      case (kind)
         PHASE_FILL: begin
            w_ins = 70; w_key = 10; w_end = 5; w_dump = 8;
         end
         PHASE_DRAIN: begin
            w_ins = 15; w_key = 30; w_end = 20; w_dump = 12;
         end
         default: begin
            w_ins = 40; w_key = 20; w_end = 10; w_dump = 17;
         end
      endcase
      unused_code = cmd_type'($urandom_range({olkd_pkg::CMD_W{1'b1}},
                                             olkd_pkg::CMD_DUMP + 1));
      if (r < w_ins) return olkd_pkg::CMD_INSERT;
      r -= w_ins;
      if (r < w_key) return olkd_pkg::CMD_DELKEY;
      r -= w_key;
      if (r < w_end) return olkd_pkg::CMD_DELFRONT;
      r -= w_end;
      if (r < w_end) return olkd_pkg::CMD_DELBACK;
      r -= w_end;
      if (r < w_dump) return olkd_pkg::CMD_DUMP;
      return unused_code;
   endfunction

   // one random phase, then a pause until every response is in
   task automatic run_phase(input phase_kind_type kind, input bit no_idle);
      cmd_type cmd;
      int      n;
      n    = 0;
      calm = no_idle;
      while (n < PHASE_ITEMS) begin
         cmd = pick_cmd(kind);
         send_request(cmd, pick_key());
         if (cmd <= olkd_pkg::CMD_DUMP) n++;
      end
      calm = 1'b0;
      random_items += n;
      drain_responses();
   endtask

   initial begin
      // every block input known from time zero
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = olkd_pkg::CMD_DUMP;
      req_key      = '0;
      rsp_stall    = 1'b0;
      calm         = 1'b0;
      quiet_cycles = 0;
      random_items = 0;
      key_pool[0]  = 32'sh8000_0000;
      key_pool[1]  = 32'sh7fff_ffff;
      key_pool[2]  = '0;
      key_pool[3]  = -1;
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: dump and every kind of delete report empty
      send_request(olkd_pkg::CMD_DUMP,     $urandom);
      send_request(olkd_pkg::CMD_DELKEY,   $urandom);
      send_request(olkd_pkg::CMD_DELFRONT, $urandom);
      send_request(olkd_pkg::CMD_DELBACK,  $urandom);

      // extreme keys, most negative one twice so delete by key has a duplicate
      send_request(olkd_pkg::CMD_INSERT, 32'sh8000_0000);
      send_request(olkd_pkg::CMD_INSERT, 32'sh7fff_ffff);
      send_request(olkd_pkg::CMD_INSERT, '0);
      send_request(olkd_pkg::CMD_INSERT, -1);
      send_request(olkd_pkg::CMD_INSERT, 32'sh8000_0000);
      send_request(olkd_pkg::CMD_DUMP, $urandom);

      // missing key, first of two equal keys, a key in the middle
      send_request(olkd_pkg::CMD_DELKEY, 32'sd12345);
      send_request(olkd_pkg::CMD_DELKEY, 32'sh8000_0000);
      send_request(olkd_pkg::CMD_DELKEY, '0);

      // unused codes must be swallowed without a response
      send_request(cmd_type'(olkd_pkg::CMD_DUMP + 1), $urandom);
      send_request(cmd_type'(olkd_pkg::CMD_DUMP + 2), $urandom);
      send_request({olkd_pkg::CMD_W{1'b1}}, $urandom);

      // ends of the list, single element dump, delete down to empty and past it
      send_request(olkd_pkg::CMD_DELFRONT, $urandom);
      send_request(olkd_pkg::CMD_DELBACK,  $urandom);
      send_request(olkd_pkg::CMD_DUMP,     $urandom);
      send_request(olkd_pkg::CMD_DELBACK,  $urandom);
      send_request(olkd_pkg::CMD_DUMP,     $urandom);
      send_request(olkd_pkg::CMD_DELBACK,  $urandom);
      drain_responses();

      // two fill phases push the list to full so inserts get dropped,
      // the second one runs with no idling on either side
      run_phase(PHASE_FILL,  1'b0);
      run_phase(PHASE_FILL,  1'b1);
      run_phase(PHASE_DRAIN, 1'b0);
      run_phase(PHASE_MIXED, 1'b0);
      run_phase(PHASE_FILL,  1'b0);
      run_phase(PHASE_DRAIN, 1'b0);

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d command transactions (%0d random) and %0d responses",
               cmd_count, random_items, rsp_count);
      $display("list filled up to %0d of %0d, statuses seen ok/full/empty/missing = %b",
               peak_fill, olkd_pkg::DEPTH_DEF,
               {status_seen[olkd_pkg::ST_OK], status_seen[olkd_pkg::ST_FULL],
                status_seen[olkd_pkg::ST_EMPTY], status_seen[olkd_pkg::ST_MISSING]});
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
